/* src/qvr_pkg.sv */
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths and types for the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

   localparam int VEC_BITS       = 16;
   localparam int QUAT_FRAC_BITS = 14;
   localparam int QUAT_BITS      = QUAT_FRAC_BITS + 2;

   // q * v product, three-term sum, p * q product, four-term sum
   localparam int PROD1_BITS = QUAT_BITS + VEC_BITS;
   localparam int P_BITS     = PROD1_BITS + 2;
   localparam int PROD2_BITS = P_BITS + QUAT_BITS;
   localparam int R_BITS     = PROD2_BITS + 2;
   localparam int SHIFT      = 2 * QUAT_FRAC_BITS;

   localparam int NUM_PROD = 12;

   localparam int REQ_FIELD_BITS = 4 * QUAT_BITS + 3 * VEC_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((3 * VEC_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic signed [QUAT_BITS-1:0] z;
      logic signed [QUAT_BITS-1:0] y;
      logic signed [QUAT_BITS-1:0] x;
      logic signed [QUAT_BITS-1:0] w;
   } quat_type;

   typedef struct packed {
      logic signed [VEC_BITS-1:0] z;
      logic signed [VEC_BITS-1:0] y;
      logic signed [VEC_BITS-1:0] x;
   } vec_type;

   typedef struct packed {
      logic signed [P_BITS-1:0] z;
      logic signed [P_BITS-1:0] y;
      logic signed [P_BITS-1:0] x;
      logic signed [P_BITS-1:0] w;
   } pquat_type;

   typedef struct packed {
      logic signed [R_BITS-1:0] z;
      logic signed [R_BITS-1:0] y;
      logic signed [R_BITS-1:0] x;
   } rvec_type;

endpackage

/* src/qvr_left_product.sv */
// ----------------------------------------------------------------------------
// qvr_left_product
// Two stages: twelve q*v products, then the sums forming p = q * (0, v).
// ----------------------------------------------------------------------------
module qvr_left_product (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  qvr_pkg::quat_type  in_quat,
   input  qvr_pkg::vec_type   in_vec,
   output logic               out_valid,
   output qvr_pkg::quat_type  out_quat,
   output qvr_pkg::pquat_type out_p
);

   localparam int PB1 = qvr_pkg::PROD1_BITS;
   localparam int PB  = qvr_pkg::P_BITS;

   logic signed [PB1-1:0] prod_in [qvr_pkg::NUM_PROD];
   logic signed [PB1-1:0] prod_ff [qvr_pkg::NUM_PROD];
   qvr_pkg::quat_type     quat_a_ff;
   logic                  valid_a_ff;
   qvr_pkg::pquat_type    p_in;
   qvr_pkg::pquat_type    p_ff;
   qvr_pkg::quat_type     quat_b_ff;
   logic                  valid_b_ff;

   always_comb begin
      prod_in[0]  = PB1'(in_quat.x) * PB1'(in_vec.x);
      prod_in[1]  = PB1'(in_quat.y) * PB1'(in_vec.y);
      prod_in[2]  = PB1'(in_quat.z) * PB1'(in_vec.z);
      prod_in[3]  = PB1'(in_quat.y) * PB1'(in_vec.z);
      prod_in[4]  = PB1'(in_quat.z) * PB1'(in_vec.y);
      prod_in[5]  = PB1'(in_quat.w) * PB1'(in_vec.x);
      prod_in[6]  = PB1'(in_quat.z) * PB1'(in_vec.x);
      prod_in[7]  = PB1'(in_quat.x) * PB1'(in_vec.z);
      prod_in[8]  = PB1'(in_quat.w) * PB1'(in_vec.y);
      prod_in[9]  = PB1'(in_quat.x) * PB1'(in_vec.y);
      prod_in[10] = PB1'(in_quat.y) * PB1'(in_vec.x);
      prod_in[11] = PB1'(in_quat.w) * PB1'(in_vec.z);
   end

   always_comb begin
      p_in.w = -PB'(prod_ff[0]) - PB'(prod_ff[1]) - PB'(prod_ff[2]);
      p_in.x =  PB'(prod_ff[3]) - PB'(prod_ff[4]) + PB'(prod_ff[5]);
      p_in.y =  PB'(prod_ff[6]) - PB'(prod_ff[7]) + PB'(prod_ff[8]);
      p_in.z =  PB'(prod_ff[9]) - PB'(prod_ff[10]) + PB'(prod_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= prod_in;
         quat_a_ff <= in_quat;
         p_ff      <= p_in;
         quat_b_ff <= quat_a_ff;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_quat  = quat_b_ff;
   assign out_p     = p_ff;

endmodule

/* src/qvr_right_product.sv */
// ----------------------------------------------------------------------------
// qvr_right_product
// Two stages: twelve p*q products, then the vector part of p * conj(q).
// ----------------------------------------------------------------------------
module qvr_right_product (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  qvr_pkg::quat_type  in_quat,
   input  qvr_pkg::pquat_type in_p,
   output logic               out_valid,
   output qvr_pkg::rvec_type  out_r
);

   localparam int PB2 = qvr_pkg::PROD2_BITS;
   localparam int RB  = qvr_pkg::R_BITS;

   logic signed [PB2-1:0] prod_in [qvr_pkg::NUM_PROD];
   logic signed [PB2-1:0] prod_ff [qvr_pkg::NUM_PROD];
   logic                  valid_a_ff;
   qvr_pkg::rvec_type     r_in;
   qvr_pkg::rvec_type     r_ff;
   logic                  valid_b_ff;

   always_comb begin
      prod_in[0]  = PB2'(in_p.y) * PB2'(in_quat.z);
      prod_in[1]  = PB2'(in_p.z) * PB2'(in_quat.y);
      prod_in[2]  = PB2'(in_p.x) * PB2'(in_quat.w);
      prod_in[3]  = PB2'(in_p.w) * PB2'(in_quat.x);
      prod_in[4]  = PB2'(in_p.z) * PB2'(in_quat.x);
      prod_in[5]  = PB2'(in_p.x) * PB2'(in_quat.z);
      prod_in[6]  = PB2'(in_p.y) * PB2'(in_quat.w);
      prod_in[7]  = PB2'(in_p.w) * PB2'(in_quat.y);
      prod_in[8]  = PB2'(in_p.x) * PB2'(in_quat.y);
      prod_in[9]  = PB2'(in_p.y) * PB2'(in_quat.x);
      prod_in[10] = PB2'(in_p.z) * PB2'(in_quat.w);
      prod_in[11] = PB2'(in_p.w) * PB2'(in_quat.z);
   end

   always_comb begin
      r_in.x = -RB'(prod_ff[0]) + RB'(prod_ff[1]) + RB'(prod_ff[2]) - RB'(prod_ff[3]);
      r_in.y = -RB'(prod_ff[4]) + RB'(prod_ff[5]) + RB'(prod_ff[6]) - RB'(prod_ff[7]);
      r_in.z = -RB'(prod_ff[8]) + RB'(prod_ff[9]) + RB'(prod_ff[10]) - RB'(prod_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         r_ff    <= r_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_r     = r_ff;

endmodule

/* src/qvr_round_sat.sv */
// ----------------------------------------------------------------------------
// qvr_round_sat
// Output stage: round to nearest, scale down and saturate each component.
// ----------------------------------------------------------------------------
module qvr_round_sat (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  qvr_pkg::rvec_type in_r,
   output logic              out_valid,
   output qvr_pkg::vec_type  out_rot,
   output logic              out_sat
);

   localparam int RB = qvr_pkg::R_BITS;
   localparam int VB = qvr_pkg::VEC_BITS;

   localparam logic signed [RB-1:0] HALF = RB'(1) << (qvr_pkg::SHIFT - 1);
   localparam logic signed [RB-1:0] MAXV = {{(RB - VB + 1){1'b0}}, {(VB - 1){1'b1}}};
   localparam logic signed [RB-1:0] MINV = ~MAXV;

   typedef struct packed {
      logic signed [VB-1:0] value;
      logic                 clamped;
   } comp_type;

   function automatic comp_type finish(input logic signed [RB-1:0] r);
      logic signed [RB-1:0] biased;
      logic signed [RB-1:0] scaled;
      comp_type             res;
      biased = r + HALF;
      scaled = biased >>> qvr_pkg::SHIFT;
      if (scaled > MAXV) begin
         res.value   = MAXV[VB-1:0];
         res.clamped = 1'b1;
      end else if (scaled < MINV) begin
         res.value   = MINV[VB-1:0];
         res.clamped = 1'b1;
      end else begin
         res.value   = scaled[VB-1:0];
         res.clamped = 1'b0;
      end
      return res;
   endfunction

   comp_type         cx;
   comp_type         cy;
   comp_type         cz;
   qvr_pkg::vec_type rot_in;
   qvr_pkg::vec_type rot_ff;
   logic             sat_in;
   logic             sat_ff;
   logic             valid_ff;

   always_comb begin
      cx       = finish(in_r.x);
      cy       = finish(in_r.y);
      cz       = finish(in_r.z);
      rot_in.x = cx.value;
      rot_in.y = cy.value;
      rot_in.z = cz.value;
      sat_in   = cx.clamped | cy.clamped | cz.clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rot_ff <= rot_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rot   = rot_ff;
   assign out_sat   = sat_ff;

endmodule

/* src/quaternion_vector_rotation_unit.sv */
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_unit
// Rotates a vector by a Q1.14 quaternion, q * (0, v) * conj(q), rounded and
// saturated back to the input scale.
// ----------------------------------------------------------------------------
// one request enters per cycle unless the output stalls; it goes through two
// multiply-then-sum pairs, one for each hamilton product, and a rounding
// stage that is also the output register. all stages move together and hold
// while a result waits on rsp_tready, so a request is taken in any cycle the
// output register is empty or being read. the quaternion is not normalized;
// a non-unit q scales the result by |q|^2 before rounding and saturation.
module quaternion_vector_rotation_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
   input  logic [qvr_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // rot_x, rot_y, rot_z
   output logic [qvr_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // saturated
   output logic                               rsp_tuser
);

   localparam int QB = qvr_pkg::QUAT_BITS;
   localparam int VB = qvr_pkg::VEC_BITS;

   logic               advance;
   qvr_pkg::quat_type  in_quat;
   qvr_pkg::vec_type   in_vec;
   logic               left_valid;
   qvr_pkg::quat_type  left_quat;
   qvr_pkg::pquat_type left_p;
   logic               right_valid;
   qvr_pkg::rvec_type  right_r;
   qvr_pkg::vec_type   rot;

   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance;

   assign in_quat.w = req_tdata[0*QB +: QB];
   assign in_quat.x = req_tdata[1*QB +: QB];
   assign in_quat.y = req_tdata[2*QB +: QB];
   assign in_quat.z = req_tdata[3*QB +: QB];
   assign in_vec.x  = req_tdata[4*QB + 0*VB +: VB];
   assign in_vec.y  = req_tdata[4*QB + 1*VB +: VB];
   assign in_vec.z  = req_tdata[4*QB + 2*VB +: VB];

   qvr_left_product u_left (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_quat   (in_quat),
      .in_vec    (in_vec),
      .out_valid (left_valid),
      .out_quat  (left_quat),
      .out_p     (left_p)
   );

   qvr_right_product u_right (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (left_valid),
      .in_quat   (left_quat),
      .in_p      (left_p),
      .out_valid (right_valid),
      .out_r     (right_r)
   );

   qvr_round_sat u_round (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (right_valid),
      .in_r      (right_r),
      .out_valid (rsp_tvalid),
      .out_rot   (rot),
      .out_sat   (rsp_tuser)
   );

   assign rsp_tdata = qvr_pkg::RSP_TDATA_BITS'({rot.z, rot.y, rot.x});

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for quaternion_vector_rotation_unit. Requests flow through
// a bursty stream driver against a receiver that stalls on shifting patterns.
// Each accepted request is predicted in 64-bit integer math, which is exact
// at these widths. Results are checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_REQUESTS = 1200;
   localparam int VB = qvr_pkg::VEC_BITS;
   localparam int QB = qvr_pkg::QUAT_BITS;
   localparam longint VEC_MAX = (64'sd1 <<< (VB - 1)) - 1;
   localparam longint VEC_MIN = -VEC_MAX - 1;

   typedef struct {
      qvr_pkg::quat_type quat;
      qvr_pkg::vec_type  vec;
      bit                drain_first;
   } rotation_request_type;

   typedef struct {
      qvr_pkg::vec_type rot;
      logic             saturated;
   } rotation_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
   logic [qvr_pkg::REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   // rot_x, rot_y, rot_z
   logic [qvr_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   // saturated
   logic                               rsp_tuser;

   rotation_request_type pending_requests[$];
   rotation_type         expected_rotations[$];
   rotation_request_type next_request;
   rotation_type         oldest_rotation;
   logic                 req_fire = 1'b0;
   int                   mismatch_count = 0;
   int                   burst_left = 0;
   int                   gap_left = 0;
   int                   ready_left = 0;
   int                   ready_phase = 0;
   ready_mode_type       ready_mode = READY_ALWAYS;

   quaternion_vector_rotation_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // q * (0, v) * conj(q), scaled down, rounded half up, clamped
   function automatic rotation_type rotate_by_quaternion(qvr_pkg::quat_type q,
                                                         qvr_pkg::vec_type v);
      longint       qw, qx, qy, qz, vx, vy, vz;
      longint       pw, px, py, pz;
      longint       acc[3];
      longint       scaled;
      rotation_type res;
      logic [VB-1:0] comp[3];
      qw = $signed(q.w);
      qx = $signed(q.x);
      qy = $signed(q.y);
      qz = $signed(q.z);
      vx = $signed(v.x);
      vy = $signed(v.y);
      vz = $signed(v.z);
      pw = -vx * qx - vy * qy - vz * qz;
      px = vz * qy - vy * qz + vx * qw;
      py = vx * qz - vz * qx + vy * qw;
      pz = vy * qx - vx * qy + vz * qw;
      acc[0] = -py * qz + pz * qy + px * qw - pw * qx;
      acc[1] = -pz * qx + px * qz + py * qw - pw * qy;
      acc[2] = -px * qy + py * qx + pz * qw - pw * qz;
      res.saturated = 1'b0;
      for (int i = 0; i < 3; i++) begin
         scaled = (acc[i] + (64'sd1 <<< (qvr_pkg::SHIFT - 1))) >>> qvr_pkg::SHIFT;
         if (scaled > VEC_MAX) begin
            scaled = VEC_MAX;
            res.saturated = 1'b1;
         end else if (scaled < VEC_MIN) begin
            scaled = VEC_MIN;
            res.saturated = 1'b1;
         end
         comp[i] = scaled[VB-1:0];
      end
      res.rot.x = comp[0];
      res.rot.y = comp[1];
      res.rot.z = comp[2];
      return res;
   endfunction

   function automatic rotation_request_type make_request(int qw, int qx, int qy, int qz,
                                                         int vx, int vy, int vz,
                                                         bit drain_first);
      rotation_request_type r;
      r.quat.w = qw[QB-1:0];
      r.quat.x = qx[QB-1:0];
      r.quat.y = qy[QB-1:0];
      r.quat.z = qz[QB-1:0];
      r.vec.x  = vx[VB-1:0];
      r.vec.y  = vy[VB-1:0];
      r.vec.z  = vz[VB-1:0];
      r.drain_first = drain_first;
      return r;
   endfunction

   function automatic rotation_request_type random_request(bit drain_first);
      int  kind;
      int  q[4];
      int  v[3];
      real c[4];
      real norm;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 4; i++) begin
         if (kind <= 4)
            c[i] = real'($urandom_range(0, 20000)) - 10000.0;
         else if (kind <= 7)
            q[i] = $urandom_range(0, 32768) - 16384;
         else if (kind == 8)
            q[i] = $urandom_range(0, 65535) - 32768;
         else
            q[i] = $urandom_range(0, 8) - 4;
      end
      if (kind <= 4) begin
         norm = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
         if (norm < 1.0) begin
            c[0] = 1.0;
            norm = 1.0;
         end
         for (int i = 0; i < 4; i++)
            q[i] = $rtoi(c[i] * 16384.0 / norm);
      end
      for (int i = 0; i < 3; i++) begin
         if ($urandom_range(0, 3) == 0)
            v[i] = $urandom_range(0, 2048) - 1024;
         else
            v[i] = $urandom_range(0, 65535) - 32768;
      end
      return make_request(q[0], q[1], q[2], q[3], v[0], v[1], v[2], drain_first);
   endfunction

   task automatic check_field(string field, longint expected, longint actual);
      if (expected != actual) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, field, expected, actual);
         mismatch_count++;
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (pending_requests[0].drain_first && expected_rotations.size() != 0) begin
            req_tvalid <= 1'b0;
         end else begin
            next_request = pending_requests.pop_front();
            next_request.drain_first = 1'b0;
            req_tdata  <= qvr_pkg::REQ_TDATA_BITS'({next_request.vec, next_request.quat});
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // response stall pattern
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_left = $urandom_range(16, 96);
      end else begin
         ready_left--;
      end
      ready_phase++;
      case (ready_mode)
         READY_ALWAYS: begin
            rsp_tready <= 1'b1;
         end
         READY_COIN: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         READY_SPARSE: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_tready <= (ready_phase % 5) != 4;
         end
      endcase
   end

   // request capture and response check
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready)
            expected_rotations.push_back(rotate_by_quaternion(
               req_tdata[4*QB-1:0],
               req_tdata[4*QB+3*VB-1:4*QB]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rotations.size() == 0) begin
               $display("%0t ns: response with none expected, expected none, actual %h %b",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               oldest_rotation = expected_rotations.pop_front();
               check_field("rot_x", $signed(oldest_rotation.rot.x),
                           $signed(rsp_tdata[VB-1:0]));
               check_field("rot_y", $signed(oldest_rotation.rot.y),
                           $signed(rsp_tdata[2*VB-1:VB]));
               check_field("rot_z", $signed(oldest_rotation.rot.z),
                           $signed(rsp_tdata[3*VB-1:2*VB]));
               check_field("saturated", oldest_rotation.saturated, rsp_tuser);
            end
         end
      end
   end

   initial begin
      // identity, zero and negated unit quaternions
      pending_requests.push_back(make_request(16384, 0, 0, 0, 32767, -32768, 1, 0));
      pending_requests.push_back(make_request(16384, 0, 0, 0, -1, 0, -32768, 0));
      pending_requests.push_back(make_request(0, 0, 0, 0, 32767, -32768, 32767, 0));
      pending_requests.push_back(make_request(-16384, 0, 0, 0, 32767, 32767, -32768, 0));
      // half turns about each axis, negating the most negative value clamps
      pending_requests.push_back(make_request(0, 16384, 0, 0, 1000, -32768, 32767, 0));
      pending_requests.push_back(make_request(0, 0, 16384, 0, -32768, 5, -32768, 0));
      pending_requests.push_back(make_request(0, 0, 0, 16384, 123, -456, 789, 0));
      pending_requests.push_back(make_request(0, 0, 0, -16384, -32768, -32768, 0, 0));
      // quarter turn about z
      pending_requests.push_back(make_request(11585, 0, 0, 11585, 10000, -20000, 300, 0));
      // exact halfway points round up
      pending_requests.push_back(make_request(8192, 8192, 0, 0, 1, 0, 0, 0));
      pending_requests.push_back(make_request(8192, 8192, 0, 0, -1, 0, 0, 0));
      pending_requests.push_back(make_request(8192, 8192, 0, 0, 0, 1, -1, 0));
      pending_requests.push_back(make_request(8192, 0, -8192, 0, -1, -1, 1, 0));
      // range extremes and non-unit quaternions
      pending_requests.push_back(make_request(16384, 16384, 16384, 16384,
                                              32767, 32767, 32767, 0));
      pending_requests.push_back(make_request(-16384, -16384, -16384, -16384,
                                              -32768, -32768, -32768, 0));
      pending_requests.push_back(make_request(-32768, -32768, -32768, -32768,
                                              -32768, -32768, -32768, 0));
      pending_requests.push_back(make_request(32767, 32767, 32767, 32767,
                                              32767, -32768, 32767, 0));
      pending_requests.push_back(make_request(21845, -21846, 21845, -21846,
                                              21845, -21846, 21845, 0));
      pending_requests.push_back(make_request(1, -1, 1, -1, 32767, -32768, 32767, 0));
      pending_requests.push_back(make_request(8192, 0, 0, 0, 32767, -32768, 3, 0));
      pending_requests.push_back(make_request(-16384, 16384, -16384, 16384, 1, -1, 2, 0));
      for (int i = 0; i < RANDOM_REQUESTS; i++)
         pending_requests.push_back(random_request(i == 0 || $urandom_range(0, 199) == 0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_requests.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_rotations.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("quaternion_vector_rotation_unit regression: pass");
      else
         $display("quaternion_vector_rotation_unit regression: fail");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("quaternion_vector_rotation_unit regression: fail");
      $finish;
   end

endmodule

/* quaternion_vector_rotation_unit.f */
src/qvr_pkg.sv
src/qvr_left_product.sv
src/qvr_right_product.sv
src/qvr_round_sat.sv
src/quaternion_vector_rotation_unit.sv
sim/tb_top.sv
